@@ hdl/tps_pkg.sv @@
package tps_pkg;

  // Parameter defaults for the top level.
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Pixel and register widths.
  localparam int PIX_BITS         = 32;
  localparam int CFG_WIDTH_BITS   = 12;
  localparam int CFG_HEIGHT_BITS  = 13;
  localparam int PADDR_BITS       = 3;
  localparam logic [31:0] ALPHA_MASK = 32'hFF000000;

  // Register word indexes, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Reciprocal scale for the averaging divide.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;

  // One averaging job. Neighbors 0..2 are the row above (left, center, right),
  // 3..5 the row below. A neighbor outside the frame is already zeroed.
  typedef struct packed {
    logic [5:0][PIX_BITS-1:0] nb;
    logic [PIX_BITS-1:0]      own;
    logic                     run_end;
    logic                     frame_end;
  } job_t;

  // Rounded-up 2^16/c for neighbor counts 1..6; zero count gives zero.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [2:0] cnt);
    logic [RECIP_BITS-1:0] r;
    case (cnt)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd32768;
      3'd3:    r = 17'd21846;
      3'd4:    r = 17'd16384;
      3'd5:    r = 17'd13108;
      3'd6:    r = 17'd10923;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tps_front.sv @@
module tps_front #(
  parameter int MAX_WIDTH  = tps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [tps_pkg::CFG_WIDTH_BITS-1:0]  cfg_width,
  input  logic [tps_pkg::CFG_HEIGHT_BITS-1:0] cfg_height,
  input  logic                                restart,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tps_pkg::PIX_BITS-1:0]        s_tdata,
  output logic                                push,
  input  logic                                push_ready,
  output tps_pkg::job_t                       push_job
);
  import tps_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  // One-hot job selects: center row at column x-1 (row y-1, then row y),
  // then the right edge column (row y-1, then row y).
  localparam logic [3:0] SEL_MID_LEFT  = 4'b0001;
  localparam logic [3:0] SEL_LAST_LEFT = 4'b0010;
  localparam logic [3:0] SEL_MID_EDGE  = 4'b0100;
  localparam logic [3:0] SEL_LAST_EDGE = 4'b1000;

  logic [1:0]          state;
  logic [XW-1:0]       col;
  logic [YW-1:0]       row;
  logic [XW-1:0]       x_last;
  logic [YW-1:0]       y_last;
  logic [31:0]         w32;
  logic [31:0]         h32;
  logic [PIX_BITS-1:0] pix;
  logic [2*PIX_BITS-1:0] rd_data;
  logic [2*PIX_BITS-1:0] mem [MAX_WIDTH];
  logic [PIX_BITS-1:0] win_top [3];
  logic [PIX_BITS-1:0] win_mid [3];
  logic [PIX_BITS-1:0] win_bot [3];
  logic [3:0]          jobs;
  logic [3:0]          jobs_next;
  logic [3:0]          sel;
  logic [3:0]          jobs_left;
  logic                x_ge1, x_ge2, y_ge1, y_ge2;
  logic                acc;
  logic                last_col, last_row;
  logic [PIX_BITS-1:0] up [3];
  logic [PIX_BITS-1:0] dn [3];
  logic [PIX_BITS-1:0] own;
  logic                lok, rok, uok, dok;
  logic [2:0]          col_ok;

  // Effective last column and last row from the size registers.
  assign w32 = 32'(cfg_width);
  assign h32 = 32'(cfg_height);

  always_comb begin
    if (w32 == 32'd0) begin
      x_last = '0;
    end else if (w32 > 32'(MAX_WIDTH)) begin
      x_last = XW'(MAX_WIDTH - 1);
    end else begin
      x_last = XW'(w32 - 32'd1);
    end
    if (h32 == 32'd0) begin
      y_last = '0;
    end else if (h32 > 32'(MAX_HEIGHT)) begin
      y_last = YW'(MAX_HEIGHT - 1);
    end else begin
      y_last = YW'(h32 - 32'd1);
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign last_col = (col == x_last);
  assign last_row = (row == y_last);

  // Line buffer: each word holds row y-2 in the upper half, row y-1 below.
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data <= mem[col];
    end
    if (state == ST_SHIFT) begin
      mem[col] <= {rd_data[PIX_BITS-1:0], pix};
    end
  end

  // Input pixel, window shift and position flags.
  always_ff @(posedge clk) begin
    if (acc) begin
      pix <= s_tdata;
    end
    if (state == ST_SHIFT) begin
      win_top[0] <= win_top[1];
      win_top[1] <= win_top[2];
      win_top[2] <= rd_data[2*PIX_BITS-1:PIX_BITS];
      win_mid[0] <= win_mid[1];
      win_mid[1] <= win_mid[2];
      win_mid[2] <= rd_data[PIX_BITS-1:0];
      win_bot[0] <= win_bot[1];
      win_bot[1] <= win_bot[2];
      win_bot[2] <= pix;
      x_ge1      <= (col != '0);
      x_ge2      <= (col > XW'(1));
      y_ge1      <= (row != '0);
      y_ge2      <= (row > YW'(1));
    end
  end

  // Jobs owed by the current position.
  assign jobs_next = {last_col && last_row, last_col && (row != '0),
                      (col != '0) && last_row, (col != '0) && (row != '0)};

  // Lowest pending job goes out first.
  assign sel       = jobs & (~jobs + 4'd1);
  assign jobs_left = jobs & ~sel;

  // Sequencer: accept, update buffers and counters, then hand out jobs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      col   <= '0;
      row   <= '0;
      jobs  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (restart) begin
            col <= '0;
            row <= '0;
          end
          if (acc) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          jobs <= jobs_next;
          if (jobs_next != '0) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
          if (last_col) begin
            col <= '0;
            row <= last_row ? '0 : row + YW'(1);
          end else begin
            col <= col + XW'(1);
          end
        end
        ST_EMIT: begin
          if (push_ready) begin
            jobs <= jobs_left;
            if (jobs_left == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Neighbor rows and edge flags of the selected job.
  always_comb begin
    unique case (sel)
      SEL_MID_LEFT: begin
        up  = win_top;
        dn  = win_bot;
        own = win_mid[1];
        lok = x_ge2;
        rok = 1'b1;
        uok = y_ge2;
        dok = 1'b1;
      end
      SEL_LAST_LEFT: begin
        up  = win_mid;
        dn  = win_bot;
        own = win_bot[1];
        lok = x_ge2;
        rok = 1'b1;
        uok = y_ge1;
        dok = 1'b0;
      end
      SEL_MID_EDGE: begin
        up  = '{win_top[1], win_top[2], '0};
        dn  = '{win_bot[1], win_bot[2], '0};
        own = win_mid[2];
        lok = x_ge1;
        rok = 1'b0;
        uok = y_ge2;
        dok = 1'b1;
      end
      default: begin
        up  = '{win_mid[1], win_mid[2], '0};
        dn  = '{win_bot[1], win_bot[2], '0};
        own = win_bot[2];
        lok = x_ge1;
        rok = 1'b0;
        uok = y_ge1;
        dok = 1'b0;
      end
    endcase
  end

  // Zero the neighbors that lie outside the frame.
  assign col_ok = {rok, 1'b1, lok};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      push_job.nb[j]     = (col_ok[j] && uok) ? up[j] : '0;
      push_job.nb[j + 3] = (col_ok[j] && dok) ? dn[j] : '0;
    end
    push_job.own       = own;
    push_job.run_end   = (jobs_left == '0);
    push_job.frame_end = (sel == SEL_LAST_EDGE);
  end

  assign push = (state == ST_EMIT);

endmodule

@@ hdl/tps_queue.sv @@
module tps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          push_ready,
  input  tps_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tps_pkg::job_t pop_job
);
  import tps_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hdl/tps_back.sv @@
module tps_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tps_pkg::job_t                pop_job,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [tps_pkg::PIX_BITS-1:0] m_tdata,
  output logic                         m_tlast,
  output logic                         m_tuser
);
  import tps_pkg::*;

  logic                  s1_valid;
  logic                  s1_pass;
  logic [PIX_BITS-1:0]   s1_own;
  logic [10:0]           s1_r, s1_g, s1_b;
  logic [2:0]            s1_cnt;
  logic                  s1_run_end;
  logic                  s1_frame_end;
  logic                  o_ready;
  logic                  s1_ready;
  logic [10:0]           sum_r, sum_g, sum_b;
  logic [2:0]            sum_cnt;
  logic [RECIP_BITS-1:0] rc;
  logic [27:0]           prod_r, prod_g, prod_b;
  logic [PIX_BITS-1:0]   result;

  assign o_ready   = !m_tvalid || m_tready;
  assign s1_ready  = !s1_valid || o_ready;
  assign pop_ready = s1_ready;

  // Channel sums over the neighbors whose alpha is not zero.
  always_comb begin
    sum_r   = '0;
    sum_g   = '0;
    sum_b   = '0;
    sum_cnt = '0;
    for (int j = 0; j < 6; j++) begin
      if ((pop_job.nb[j] & ALPHA_MASK) != '0) begin
        sum_r   = sum_r + 11'(pop_job.nb[j][23:16]);
        sum_g   = sum_g + 11'(pop_job.nb[j][15:8]);
        sum_b   = sum_b + 11'(pop_job.nb[j][7:0]);
        sum_cnt = sum_cnt + 3'd1;
      end
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pop_valid) begin
      s1_pass      <= ((pop_job.own & ALPHA_MASK) != '0);
      s1_own       <= pop_job.own;
      s1_r         <= sum_r;
      s1_g         <= sum_g;
      s1_b         <= sum_b;
      s1_cnt       <= sum_cnt;
      s1_run_end   <= pop_job.run_end;
      s1_frame_end <= pop_job.frame_end;
    end
  end

  // Mean by reciprocal multiply; a zero count yields zero.
  assign rc     = recip(s1_cnt);
  assign prod_r = 28'(s1_r) * 28'(rc);
  assign prod_g = 28'(s1_g) * 28'(rc);
  assign prod_b = 28'(s1_b) * 28'(rc);
  assign result = s1_pass ? s1_own
                          : {8'h00, prod_r[RECIP_SHIFT +: 8], prod_g[RECIP_SHIFT +: 8],
                             prod_b[RECIP_SHIFT +: 8]};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (o_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s1_valid) begin
      m_tdata <= result;
      m_tlast <= s1_run_end;
      m_tuser <= s1_frame_end;
    end
  end

endmodule

@@ hdl/transparent_pixel_sanding.sv @@
// Path: beat register, window shift, job queue, sum stage, output register;
// results run one row and one pixel behind the input in raster terms.
// Input: a beat causes 0..4 results; the front takes the next beat only after
// the buffer read and write and its jobs, one per cycle when the queue has room.
// Reset (rst, synchronous, active high) clears control state and sets the frame
// to 1 x 1; the line buffers are not cleared and need no clearing pass.
module transparent_pixel_sanding #(
  parameter int MAX_WIDTH  = tps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tps_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // in_pixel[31:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,   // out_pixel[31:0]
  output logic                           m_tlast,   // run_end
  output logic                           m_tuser    // frame_end
);
  import tps_pkg::*;

  logic [CFG_WIDTH_BITS-1:0]  image_width;
  logic [CFG_HEIGHT_BITS-1:0] image_height;
  logic                       cfg_wr;
  logic                       q_push;
  logic                       q_push_ready;
  job_t                       q_push_job;
  logic                       q_pop_valid;
  logic                       q_pop_ready;
  job_t                       q_pop_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Size registers; a write restarts the frame when the front is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_WIDTH_BITS'(1);
      image_height <= CFG_HEIGHT_BITS'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_HEIGHT_BITS-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  tps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_width  (image_width),
    .cfg_height (image_height),
    .restart    (cfg_wr),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_job   (q_push_job)
  );

  tps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  tps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_job   (q_pop_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

@@ hdl/tps_checker.sv @@
module tps_checker (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // The output register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  // A stalled result beat keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result beat changed");

  // The frame's last pixel is always the last result of its input beat.
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without run end");

  // Input beats are taken one at a time; the next is not taken at once.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input beat accepted on back-to-back cycles");

  // The register port never waits.
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind transparent_pixel_sanding tps_checker u_tps_checker (.*);
